[hw/rtl/lrup_pkg.sv]
// ----------------------------------------------------------------------------
// lrup_pkg
// Shared constants, codes and types for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrup_pkg;

  // default sizes
  localparam int FramesDef   = 16;
  localparam int PageBitsDef = 16;
  localparam int AgeBitsDef  = 16;

  // fixed port field widths
  localparam int PageW     = 16;
  localparam int OutcomeW  = 2;
  localparam int FiuW      = 5;
  localparam int CfgDataW  = 16;
  localparam int CfgIdxW   = 1;

  // register reset values
  localparam logic [FiuW-1:0]  FiuRst     = 5'd16;
  localparam logic [PageW-1:0] MaxPageRst = 16'hFFFF;

  typedef enum logic [OutcomeW-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_REPL  = 2'd2,
    OUT_RANGE = 2'd3
  } outcome_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAMES_IN_USE = 1'b0,
    REG_MAX_PAGE      = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SWEEP = 1'b1
  } state_e;

endpackage

[hw/rtl/lru_page_replacement.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement with aging counters over a row of frame cells.
// ----------------------------------------------------------------------------
// done_o follows the search; when out of range it comes in the cycle after the request
// a new request is taken only while idle, not during a search; out-of-range requests can
//   come every cycle. The search wave moves one frame cell per cycle along the row
// reset: clears valid marks, ages, fill and replacement counts; page store is not reset
// done_o is a one-cycle strobe, the receiver cannot stall
module lru_page_replacement #(
  parameter int FRAMES    = lrup_pkg::FramesDef,
  parameter int PAGE_BITS = lrup_pkg::PageBitsDef,
  parameter int AGE_BITS  = lrup_pkg::AgeBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [lrup_pkg::PageW-1:0]     page_i,
  output logic                           done_o,
  output logic [lrup_pkg::OutcomeW-1:0]  outcome_o,
  input  logic                           cfg_we_i,
  input  logic [lrup_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lrup_pkg::CfgDataW-1:0]  cfg_data_i
);

  import lrup_pkg::*;

  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);

  // configuration
  logic [FiuW-1:0]  fiu_q;
  logic [PageW-1:0] max_page_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q      <= FiuRst;
      max_page_q <= MaxPageRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAMES_IN_USE: fiu_q      <= cfg_data_i[FiuW-1:0];
        REG_MAX_PAGE:      max_page_q <= cfg_data_i[PageW-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] n_active;

  always_comb begin
    if (fiu_q == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(fiu_q) > FRAMES) begin
      n_active = CNT_W'(FRAMES);
    end else begin
      n_active = CNT_W'(fiu_q);
    end
  end

  // control
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     filled_q, filled_d;
  logic [31:0]          repl_q, repl_d;
  logic [PAGE_BITS-1:0] req_page_q, req_page_d;
  logic                 done_q, done_d;
  outcome_e             outcome_q, outcome_d;

  logic             accept;
  logic             upd;
  logic             wr;
  logic [IDX_W-1:0] tgt;

  // search chain taps
  logic                chain_hit      [FRAMES+1];
  logic [IDX_W-1:0]    chain_hit_idx  [FRAMES+1];
  logic [AGE_BITS-1:0] chain_best_age [FRAMES+1];
  logic [IDX_W-1:0]    chain_best_idx [FRAMES+1];

  assign chain_hit[0]      = 1'b0;
  assign chain_hit_idx[0]  = '0;
  assign chain_best_age[0] = '0;
  assign chain_best_idx[0] = '0;

  assign accept = start && (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    filled_d   = filled_q;
    repl_d     = repl_q;
    req_page_d = req_page_q;
    done_d     = 1'b0;
    outcome_d  = outcome_q;
    upd        = 1'b0;
    wr         = 1'b0;
    tgt        = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (page_i > max_page_q) begin
            done_d    = 1'b1;
            outcome_d = OUT_RANGE;
          end else begin
            req_page_d = PAGE_BITS'(page_i);
            cnt_d      = '0;
            state_d    = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        cnt_d = cnt_q + CNT_W'(1);
        // last frame holds the full search result
        if (cnt_q == CNT_W'(FRAMES)) begin
          upd     = 1'b1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (chain_hit[FRAMES]) begin
            tgt       = chain_hit_idx[FRAMES];
            outcome_d = OUT_HIT;
          end else if (filled_q < n_active) begin
            tgt       = IDX_W'(filled_q);
            wr        = 1'b1;
            filled_d  = filled_q + CNT_W'(1);
            outcome_d = OUT_FILL;
          end else begin
            tgt       = chain_best_idx[FRAMES];
            wr        = 1'b1;
            outcome_d = OUT_REPL;
            if (repl_q != '1) begin
              repl_d = repl_q + 32'd1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      filled_q <= '0;
      repl_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      filled_q <= filled_d;
      repl_q   <= repl_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_page_q <= req_page_d;
    outcome_q  <= outcome_d;
  end

  // frame row
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lrup_cell #(
      .IDX       (g),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .PAGE_BITS (PAGE_BITS),
      .AGE_BITS  (AGE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .n_active_i (n_active),
      .page_i     (req_page_q),
      .upd_i      (upd),
      .wr_i       (wr),
      .tgt_i      (tgt),
      .hit_i      (chain_hit[g]),
      .hit_idx_i  (chain_hit_idx[g]),
      .best_age_i (chain_best_age[g]),
      .best_idx_i (chain_best_idx[g]),
      .hit_o      (chain_hit[g+1]),
      .hit_idx_o  (chain_hit_idx[g+1]),
      .best_age_o (chain_best_age[g+1]),
      .best_idx_o (chain_best_idx[g+1])
    );
  end

  assign busy      = (state_q != ST_IDLE);
  assign done_o    = done_q;
  assign outcome_o = outcome_q;

endmodule

[hw/rtl/lrup_cell.sv]
// ----------------------------------------------------------------------------
// lrup_cell
// One page frame: holds page, valid mark and age, and forwards the running
// hit and oldest-frame search to the next frame every cycle.
// ----------------------------------------------------------------------------
module lrup_cell #(
  parameter int IDX       = 0,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5,
  parameter int PAGE_BITS = 16,
  parameter int AGE_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request broadcast
  input  logic [CNT_W-1:0]     n_active_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic                 upd_i,
  input  logic                 wr_i,
  input  logic [IDX_W-1:0]     tgt_i,
  // search chain from the previous frame
  input  logic                 hit_i,
  input  logic [IDX_W-1:0]     hit_idx_i,
  input  logic [AGE_BITS-1:0]  best_age_i,
  input  logic [IDX_W-1:0]     best_idx_i,
  // search chain to the next frame
  output logic                 hit_o,
  output logic [IDX_W-1:0]     hit_idx_o,
  output logic [AGE_BITS-1:0]  best_age_o,
  output logic [IDX_W-1:0]     best_idx_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MyCnt = CNT_W'(IDX);

  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 valid_q, valid_d;
  logic [AGE_BITS-1:0]  age_q, age_d;
  logic                 hit_q, hit_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic [AGE_BITS-1:0]  best_age_q, best_age_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;

  logic active, match, take, sel;

  assign active = (MyCnt < n_active_i);
  assign match  = valid_q && active && (page_q == page_i);
  // later frames win ties
  assign take   = active && (age_q >= best_age_i);
  assign sel    = (tgt_i == MyIdx);

  always_comb begin
    hit_d      = hit_i | match;
    hit_idx_d  = hit_i ? hit_idx_i : MyIdx;
    best_age_d = take ? age_q : best_age_i;
    best_idx_d = take ? MyIdx : best_idx_i;

    page_d  = page_q;
    valid_d = valid_q;
    age_d   = age_q;
    if (upd_i) begin
      if (active && (age_q != '1)) begin
        age_d = age_q + AGE_BITS'(1);
      end
      if (sel) begin
        age_d = '0;
        if (wr_i) begin
          page_d  = page_i;
          valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    best_age_q <= best_age_d;
    best_idx_q <= best_idx_d;
  end

  assign hit_o      = hit_q;
  assign hit_idx_o  = hit_idx_q;
  assign best_age_o = best_age_q;
  assign best_idx_o = best_idx_q;

endmodule

[hw/rtl/lrup_checker.sv]
// ----------------------------------------------------------------------------
// lrup_checker
// Port-level checks for the LRU page replacement block, bound to the top.
// ----------------------------------------------------------------------------
module lrup_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           done_o,
  input  logic [lrup_pkg::OutcomeW-1:0]  outcome_o
);

  import lrup_pkg::*;

  // a result never overlaps a search in progress
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("done_o while busy");

  // a search only begins on a request
  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // every search ends with a result
  a_busy_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("search ended without a result");

  // hit, fill and replace only come out of a search
  a_search_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (outcome_o != OUT_RANGE)) |-> $past(busy))
    else $error("search result without a search");

endmodule

bind lru_page_replacement lrup_checker u_lrup_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done_o    (done_o),
  .outcome_o (outcome_o)
);

[tb/sv/tb_lru_page_replacement.sv]
// ----------------------------------------------------------------------------
// tb_lru_page_replacement
// Self-checking bench for the LRU page replacement block. A queue of page
// requests and register writes feeds a clocked driver; a clocked monitor
// compares every outcome against an aging-counter LRU predictor that runs in
// step with each accepted request.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
  timeunit 1ns;
  timeprecision 1ps;

  import lrup_pkg::*;

  typedef enum logic [1:0] {
    OP_REQ,
    OP_CFG,
    OP_DRAIN
  } op_kind_e;

  typedef struct {
    op_kind_e         kind;
    logic [PageW-1:0] page;
    cfg_reg_e         idx;
    logic [15:0]      data;
  } op_t;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                start      = 1'b0;
  logic                busy;
  logic [PageW-1:0]    page_i     = '0;
  logic                done_o;
  logic [OutcomeW-1:0] outcome_o;
  logic                cfg_we_i   = 1'b0;
  cfg_reg_e            cfg_idx_i  = REG_FRAMES_IN_USE;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  op_t      pending_ops[$];
  outcome_e expected_outcomes[$];
  int       in_flight     = 0;
  int       accepted_reqs = 0;
  int       queued_reqs   = 0;
  int       err_count     = 0;

  // predictor state
  logic [PageW-1:0]      frame_pg[FramesDef];
  bit                    frame_ok[FramesDef];
  logic [AgeBitsDef-1:0] frame_ag[FramesDef];
  int unsigned           fill_count;
  logic [31:0]           repl_count;
  logic [FiuW-1:0]       cur_frames;
  logic [PageW-1:0]      cur_max_page;

  lru_page_replacement dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .page_i     (page_i),
    .done_o     (done_o),
    .outcome_o  (outcome_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned frames_active(logic [FiuW-1:0] fiu);
    if (fiu == 0) return 1;
    if (fiu > FramesDef) return FramesDef;
    return fiu;
  endfunction

  function automatic void age_frames(int unsigned n);
    int unsigned j;
    for (j = 0; j < n; j++) begin
      if (frame_ag[j] != '1) frame_ag[j]++;
    end
  endfunction

  // one request through the LRU frame set, returns the outcome
  function automatic outcome_e lru_access(logic [PageW-1:0] pg);
    int unsigned n;
    int unsigned j;
    int unsigned slot;
    n = frames_active(cur_frames);
    if (pg > cur_max_page) return OUT_RANGE;
    for (j = 0; j < n; j++) begin
      if (frame_ok[j] && frame_pg[j] == pg) begin
        age_frames(n);
        frame_ag[j] = '0;
        return OUT_HIT;
      end
    end
    if (fill_count < n) begin
      slot = fill_count;
      frame_pg[slot] = pg;
      frame_ok[slot] = 1'b1;
      age_frames(n);
      frame_ag[slot] = '0;
      if (fill_count < FramesDef) fill_count++;
      return OUT_FILL;
    end
    // oldest frame, ties to the highest index
    slot = 0;
    for (j = 1; j < n; j++) begin
      if (frame_ag[j] >= frame_ag[slot]) slot = j;
    end
    age_frames(n);
    frame_ag[slot] = '0;
    frame_pg[slot] = pg;
    frame_ok[slot] = 1'b1;
    if (repl_count != '1) repl_count++;
    return OUT_REPL;
  endfunction

  function automatic void reg_write(cfg_reg_e idx, logic [CfgDataW-1:0] d);
    case (idx)
      REG_FRAMES_IN_USE: cur_frames = d[FiuW-1:0];
      REG_MAX_PAGE:      cur_max_page = d[PageW-1:0];
      default: ;
    endcase
  endfunction

  function automatic void push_req(logic [PageW-1:0] pg);
    op_t op;
    op.kind = OP_REQ;
    op.page = pg;
    op.idx  = REG_FRAMES_IN_USE;
    op.data = '0;
    pending_ops.push_back(op);
    queued_reqs++;
  endfunction

  function automatic void push_cfg(cfg_reg_e idx, logic [CfgDataW-1:0] d);
    op_t op;
    op.kind = OP_CFG;
    op.page = '0;
    op.idx  = idx;
    op.data = d;
    pending_ops.push_back(op);
  endfunction

  function automatic void push_drain();
    op_t op;
    op.kind = OP_DRAIN;
    op.page = '0;
    op.idx  = REG_FRAMES_IN_USE;
    op.data = '0;
    pending_ops.push_back(op);
  endfunction

  // frames_in_use write with junk in the unused upper bits
  function automatic logic [CfgDataW-1:0] fiu_word(logic [FiuW-1:0] fiu);
    logic [CfgDataW-1:0] w;
    w = CfgDataW'($urandom);
    w[FiuW-1:0] = fiu;
    return w;
  endfunction

  // driver
  always @(posedge clk_i) begin
    op_t                 head;
    logic                nxt_start;
    logic                nxt_we;
    logic [PageW-1:0]    nxt_page;
    cfg_reg_e            nxt_idx;
    logic [CfgDataW-1:0] nxt_data;
    logic                quiet;
    logic                may_idle;
    if (rst_ni) begin
      nxt_start = 1'b0;
      nxt_we    = 1'b0;
      nxt_page  = page_i;
      nxt_idx   = cfg_idx_i;
      nxt_data  = cfg_data_i;
      if (done_o === 1'b1) in_flight--;
      if (cfg_we_i) reg_write(cfg_idx_i, cfg_data_i);
      if (start && !busy) begin
        expected_outcomes.push_back(lru_access(page_i));
        in_flight++;
        accepted_reqs++;
        void'(pending_ops.pop_front());
      end
      quiet    = (in_flight == 0) && !busy;
      may_idle = !(accepted_reqs >= 400 && accepted_reqs < 650);
      if (pending_ops.size() != 0) begin
        head = pending_ops[0];
        case (head.kind)
          OP_REQ: begin
            nxt_page  = head.page;
            nxt_start = !(may_idle && $urandom_range(99) < 7);
          end
          OP_CFG: if (quiet) begin
            nxt_we   = 1'b1;
            nxt_idx  = head.idx;
            nxt_data = head.data;
            void'(pending_ops.pop_front());
          end
          OP_DRAIN: if (quiet) begin
            void'(pending_ops.pop_front());
          end
          default: ;
        endcase
      end
      start      <= nxt_start;
      page_i     <= nxt_page;
      cfg_we_i   <= nxt_we;
      cfg_idx_i  <= nxt_idx;
      cfg_data_i <= nxt_data;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    outcome_e want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_outcomes.size() == 0) begin
        $error("outcome: no request pending, actual %0d", outcome_o);
        err_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (outcome_o !== want) begin
          $error("outcome: expected %0d (%s), actual %0d", want, want.name(), outcome_o);
          err_count++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb_lru_page_replacement: errors");
    $finish;
  end

  initial begin
    int unsigned    phase;
    logic [FiuW-1:0] fiu;
    int unsigned    maxp;
    int unsigned    eff;
    int unsigned    ws;
    int unsigned    base;
    int unsigned    len;
    int unsigned    r;
    logic [PageW-1:0] pg;

    for (int i = 0; i < FramesDef; i++) begin
      frame_pg[i] = '0;
      frame_ok[i] = 1'b0;
      frame_ag[i] = '0;
    end
    fill_count   = 0;
    repl_count   = '0;
    cur_frames   = FiuRst;
    cur_max_page = MaxPageRst;

    // directed: empty frames vs page 0, range edges, frame count clamps
    push_req(16'h0000);
    push_req(16'h0000);
    push_req(16'hFFFF);
    push_req(16'hFFFF);
    push_cfg(REG_MAX_PAGE, 16'h1234);
    push_req(16'h1235);
    push_req(16'h1234);
    push_cfg(REG_FRAMES_IN_USE, fiu_word(5'd0));
    push_req(16'h0000);
    push_req(16'h0007);
    push_cfg(REG_FRAMES_IN_USE, fiu_word(5'd31));
    push_req(16'h0008);
    push_req(16'h0000);
    push_req(16'hFFFF);
    push_cfg(REG_FRAMES_IN_USE, fiu_word(5'd2));
    push_req(16'h0009);
    push_req(16'h000A);
    push_req(16'h0009);
    push_cfg(REG_MAX_PAGE, 16'h0000);
    push_req(16'h0000);
    push_req(16'h0001);
    push_req(16'hFFFF);
    push_cfg(REG_MAX_PAGE, 16'hFFFF);
    push_cfg(REG_FRAMES_IN_USE, fiu_word(5'd16));
    push_drain();

    // random phases, each with its own frame count and page limit
    phase = 0;
    while (queued_reqs < 1100) begin
      case (phase)
        0: begin fiu = 5'd1;  maxp = 65535; end
        1: begin fiu = 5'd16; maxp = 0;     end
        2: begin fiu = 5'd0;  maxp = 65535; end
        3: begin fiu = 5'd31; maxp = 40;    end
        default: begin
          r = $urandom_range(3);
          fiu = (r == 0) ? 5'($urandom_range(1, 4)) :
                (r == 1) ? 5'($urandom_range(16, 31)) : 5'($urandom_range(0, 31));
          r = $urandom_range(3);
          maxp = (r == 0) ? 65535 : (r == 1) ? $urandom_range(0, 64) :
                 (r == 2) ? $urandom_range(0, 65535) : $urandom_range(64, 65534);
        end
      endcase
      push_cfg(REG_FRAMES_IN_USE, fiu_word(fiu));
      push_cfg(REG_MAX_PAGE, 16'(maxp));
      eff  = frames_active(fiu);
      ws   = $urandom_range(1, 2 * eff + 3);
      base = (maxp + 1 < ws) ? 0 : $urandom_range(0, maxp + 1 - ws);
      len  = $urandom_range(40, 100);
      repeat (len) begin
        r = $urandom_range(99);
        if (r < 80) pg = 16'(base + $urandom_range(0, ws - 1));
        else if (r < 90 || maxp == 65535) pg = 16'($urandom);
        else pg = 16'($urandom_range(maxp + 1, 65535));
        if ($urandom_range(49) == 0) push_drain();
        push_req(pg);
      end
      phase++;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0) @(posedge clk_i);
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (FramesDef + 8) @(posedge clk_i);
    if (expected_outcomes.size() != 0) begin
      $error("outcome: %0d results never arrived", expected_outcomes.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb_lru_page_replacement: clean");
    end else begin
      $display("tb_lru_page_replacement: errors");
    end
    $finish;
  end

endmodule
